FILE: rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted (active low).
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Clocked assertion that stays live through reset.
`define ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) (prop)) \
    else $error("assertion failed");

`endif

FILE: rtl/dcfe_pkg.sv
// Types and constants for the drive command frame encoder.
// No dependencies; imported by every module of the block.
package dcfe_pkg;

  localparam logic [7:0] TOP_REAL   = 8'd240;
  localparam logic [7:0] TOP_SIM    = 8'd60;
  localparam logic [7:0] SYNC_BYTE  = 8'hFF;
  localparam logic [7:0] ADDR_BYTE  = 8'h07;
  localparam logic [15:0] CRC_INIT  = 16'hFFFF;
  localparam logic [15:0] CRC_POLY  = 16'hA001;
  localparam logic [6:0] SIM_FWD    = 7'd64;

  localparam int unsigned REAL_LEN  = 9;
  localparam int unsigned SIM_LEN   = 2;
  localparam int unsigned IDX_W     = 4;

  // byte positions in the robot frame
  localparam logic [IDX_W-1:0] POS_SYNC  = 4'd0;
  localparam logic [IDX_W-1:0] POS_ADDR  = 4'd1;
  localparam logic [IDX_W-1:0] POS_VL    = 4'd2;
  localparam logic [IDX_W-1:0] POS_PAD0  = 4'd3;
  localparam logic [IDX_W-1:0] POS_VR    = 4'd4;
  localparam logic [IDX_W-1:0] POS_PAD1  = 4'd5;
  localparam logic [IDX_W-1:0] POS_FLAGS = 4'd6;
  localparam logic [IDX_W-1:0] POS_CRCL  = 4'd7;
  localparam logic [IDX_W-1:0] POS_CRCH  = 4'd8;

  typedef enum logic [3:0] {
    CMD_FWD         = 4'd0,
    CMD_BACK        = 4'd1,
    CMD_BACK_LEFT   = 4'd2,
    CMD_BACK_RIGHT  = 4'd3,
    CMD_FWD_LEFT    = 4'd4,
    CMD_FWD_RIGHT   = 4'd5,
    CMD_PIVOT_LEFT  = 4'd6,
    CMD_PIVOT_RIGHT = 4'd7
  } drive_cmd_t;

  // one classified command, as queued between front and back
  typedef struct packed {
    logic       real_mode;
    logic [7:0] speed_l;
    logic [7:0] speed_r;
    logic       fwd_l;
    logic       fwd_r;
  } plan_t;

endpackage

FILE: rtl/dcfe_front.sv
// Front end: holds the mode register, accepts commands and classifies them
// into speed/flag plans pushed into the queue. Depends on dcfe_pkg.
module dcfe_front import dcfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [0:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_drive_command,
  input  logic       q_full,
  output logic       q_push,
  output plan_t      q_plan
);

  logic       real_mode_r;
  logic       real_mode_nxt;
  logic [7:0] top;
  logic [7:0] quarter;

  always_comb begin
    real_mode_nxt = real_mode_r;
    if (cfg_wr_en) begin
      real_mode_nxt = cfg_wr_data[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      real_mode_r <= 1'b1;
    end else begin
      real_mode_r <= real_mode_nxt;
    end
  end

  assign top      = real_mode_r ? TOP_REAL : TOP_SIM;
  assign quarter  = {2'b00, top[7:2]};
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  always_comb begin
    q_plan           = '0;
    q_plan.real_mode = real_mode_r;
    unique case (in_drive_command)
      CMD_FWD: begin
        q_plan.speed_l = top;  q_plan.speed_r = top;
        q_plan.fwd_l = 1'b1;   q_plan.fwd_r = 1'b1;
      end
      CMD_BACK: begin
        q_plan.speed_l = top;  q_plan.speed_r = top;
      end
      CMD_BACK_LEFT: begin
        q_plan.speed_l = quarter; q_plan.speed_r = top;
      end
      CMD_BACK_RIGHT: begin
        q_plan.speed_l = top;  q_plan.speed_r = quarter;
      end
      CMD_FWD_LEFT: begin
        q_plan.speed_l = quarter; q_plan.speed_r = top;
        q_plan.fwd_l = 1'b1;   q_plan.fwd_r = 1'b1;
      end
      CMD_FWD_RIGHT: begin
        q_plan.speed_l = top;  q_plan.speed_r = quarter;
        q_plan.fwd_l = 1'b1;   q_plan.fwd_r = 1'b1;
      end
      CMD_PIVOT_LEFT: begin
        q_plan.speed_l = top;  q_plan.speed_r = top;
        q_plan.fwd_r = 1'b1;
      end
      CMD_PIVOT_RIGHT: begin
        q_plan.speed_l = top;  q_plan.speed_r = top;
        q_plan.fwd_l = 1'b1;
      end
      default: begin
        // stop: zero speed, no forward flags
      end
    endcase
  end

endmodule

FILE: rtl/dcfe_queue.sv
// Small register queue of plans between front and back end.
// Depends on dcfe_pkg for plan_t.
module dcfe_queue import dcfe_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  push,
  input  plan_t push_plan,
  output logic  full,
  input  logic  pop,
  output logic  empty,
  output plan_t head_plan
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  plan_t             mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic              do_push, do_pop;

  assign full      = (count_r == FULL_CNT);
  assign empty     = (count_r == '0);
  assign head_plan = mem_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && !empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_plan;
    end
  end

endmodule

FILE: rtl/dcfe_back.sv
// Back end: serializes the head plan into frame bytes, one per cycle
// unless stalled, with a Modbus CRC and output register. Uses dcfe_pkg.
module dcfe_back import dcfe_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_empty,
  input  plan_t      q_head,
  output logic       q_pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic             valid_r, valid_nxt;
  logic [7:0]       byte_r, byte_nxt;
  logic             last_r, last_nxt;
  logic             load;
  logic [7:0]       cur_byte;
  logic             cur_last;
  logic [7:0]       flags;

  // one byte through the reflected Modbus CRC
  function automatic logic [15:0] crc_step(input logic [15:0] crc_in,
                                           input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'd0, data};
    for (int b = 0; b < 8; b++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  assign flags = {1'b0, q_head.fwd_l, 1'b0, q_head.fwd_r, 4'b0000};

  always_comb begin
    cur_byte = 8'd0;
    cur_last = 1'b0;
    if (q_head.real_mode) begin
      unique case (idx_r)
        POS_SYNC:           cur_byte = SYNC_BYTE;
        POS_ADDR:           cur_byte = ADDR_BYTE;
        POS_VL:             cur_byte = q_head.speed_l;
        POS_PAD0, POS_PAD1: cur_byte = 8'd0;
        POS_VR:             cur_byte = q_head.speed_r;
        POS_FLAGS:          cur_byte = flags;
        POS_CRCL:           cur_byte = crc_r[7:0];
        POS_CRCH: begin
          cur_byte = crc_r[15:8];
          cur_last = 1'b1;
        end
        default: begin
          cur_byte = 8'd0;
        end
      endcase
    end else begin
      // simulator frame: left byte, then right byte
      if (idx_r == '0) begin
        cur_byte = (q_head.fwd_l ? {1'b0, SIM_FWD} : 8'd0) + q_head.speed_l;
      end else begin
        cur_byte = (q_head.fwd_r ? {1'b0, SIM_FWD} : 8'd0) + q_head.speed_r;
        cur_last = 1'b1;
      end
    end
  end

  // output register takes a new byte when empty or being drained
  assign load  = !valid_r || out_ready;
  assign q_pop = load && !q_empty && cur_last;

  always_comb begin
    idx_nxt   = idx_r;
    crc_nxt   = crc_r;
    valid_nxt = valid_r;
    byte_nxt  = byte_r;
    last_nxt  = last_r;
    if (load) begin
      valid_nxt = !q_empty;
      if (!q_empty) begin
        byte_nxt = cur_byte;
        last_nxt = cur_last;
        idx_nxt  = cur_last ? '0 : idx_r + 1'b1;
        if (idx_r == POS_SYNC) begin
          crc_nxt = CRC_INIT;
        end else if (idx_r <= POS_FLAGS) begin
          crc_nxt = crc_step(crc_r, cur_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      crc_r   <= CRC_INIT;
      valid_r <= 1'b0;
      byte_r  <= 8'd0;
      last_r  <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      crc_r   <= crc_nxt;
      valid_r <= valid_nxt;
      byte_r  <= byte_nxt;
      last_r  <= last_nxt;
    end
  end

  assign out_valid      = valid_r;
  assign out_frame_byte = byte_r;
  assign out_last_byte  = last_r;

endmodule

FILE: rtl/drive_command_frame_encoder.sv
// Drive command frame encoder, top level.
// Depends on dcfe_pkg, dcfe_front, dcfe_queue, dcfe_back.
//
//  channel | ports                                    | handshake
//  --------+------------------------------------------+--------------------
//  in      | in_drive_command[3:0]                    | in_valid / in_ready
//  out     | out_frame_byte[7:0], out_last_byte       | out_valid / out_ready
//  cfg     | cfg_wr_data[0] (real_robot_mode)         | cfg_wr_en, no wait
//
// One result byte per cycle while out_ready is high; a command gives 9 bytes
// in robot mode and 2 in simulator mode, set by the back-end byte serializer.
// Commands queue up to QUEUE_DEPTH deep, so the next one is taken while the
// current frame is still going out. Synchronous active-low reset empties the
// queue, drops any partial frame and sets robot mode. A stalled out_ready
// holds the output byte; once the queue fills, in_ready drops.
module drive_command_frame_encoder import dcfe_pkg::*; #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_wr_en,
  input  logic [0:0] cfg_wr_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [3:0] in_drive_command,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_frame_byte,
  output logic       out_last_byte
);

  logic  q_push, q_pop, q_full, q_empty;
  plan_t q_plan, q_head;

  dcfe_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_wr_data      (cfg_wr_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_drive_command (in_drive_command),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_plan           (q_plan)
  );

  dcfe_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_plan (q_plan),
    .full      (q_full),
    .pop       (q_pop),
    .empty     (q_empty),
    .head_plan (q_head)
  );

  dcfe_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_head         (q_head),
    .q_pop          (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_frame_byte (out_frame_byte),
    .out_last_byte  (out_last_byte)
  );

endmodule

FILE: rtl/dcfe_checker.sv
// Port-level checker for the drive command frame encoder, with its bind.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module dcfe_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       cfg_wr_en,
  input logic [0:0] cfg_wr_data,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_frame_byte,
  input logic       out_last_byte
);

  logic mode_r;
  logic first_r;

  // track the frame boundary and the mode as seen on the ports
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= 1'b1;
      first_r <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data[0];
      end
      if (out_valid && out_ready) begin
        first_r <= out_last_byte;
      end
    end
  end

  `ASSERT_ALWAYS(a_reset_clears_out, clk, !rst_n |=> !out_valid)
  `ASSERT_CLK(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_frame_byte) && $stable(out_last_byte))
  `ASSERT_CLK(a_robot_head, clk, rst_n,
    out_valid && first_r && mode_r |-> out_frame_byte == 8'hFF && !out_last_byte)
  `ASSERT_CLK(a_sim_len, clk, rst_n, out_valid && !first_r && !mode_r |-> out_last_byte)

endmodule

bind drive_command_frame_encoder dcfe_checker u_dcfe_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_wr_en      (cfg_wr_en),
  .cfg_wr_data    (cfg_wr_data),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_frame_byte (out_frame_byte),
  .out_last_byte  (out_last_byte)
);
